/* rtl/rgb2hsv_pkg.sv */
// Package for the RGB to HSV conversion core: widths, hue scaling constants,
// sector codes, the per-item sideband record and the sector offset function. No dependencies.
`timescale 1ns / 1ps

package rgb2hsv_pkg;

  localparam int CHAN_W            = 8;
  localparam int CHAN_MAX          = (1 << CHAN_W) - 1;
  localparam int HUE_FRACTION_BITS = 6;
  localparam int HUE_W             = 15;
  localparam int HUE_UNIT          = 60 << HUE_FRACTION_BITS;
  localparam int HUE_TURN          = 360 << HUE_FRACTION_BITS;
  localparam int HUE_QW            = $clog2(HUE_UNIT + 1);
  localparam int HUE_NUM_W         = $clog2(HUE_UNIT * CHAN_MAX + 1);
  localparam int SAT_QW            = CHAN_W;
  localparam int SAT_NUM_W         = 2 * CHAN_W;
  localparam int DIV_N             = (HUE_QW > SAT_QW) ? HUE_QW : SAT_QW;
  localparam int HUE_CALC_W        = $clog2(HUE_TURN) + 2;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Values that ride alongside the two dividers.
  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] delta;
    sector_t           sector;
    logic              neg;
  } side_t;

  // Hue offset of a sector: 0, 120 or 240 degrees in hue units.
  function automatic logic [HUE_CALC_W-1:0] sector_base(input sector_t s);
    logic [HUE_CALC_W-1:0] b;
    unique case (s)
      SEC_RED:   b = '0;
      SEC_GREEN: b = HUE_CALC_W'(2 * HUE_UNIT);
      SEC_BLUE:  b = HUE_CALC_W'(4 * HUE_UNIT);
      default:   b = '0;
    endcase
    return b;
  endfunction

endpackage

/* rtl/rgb_to_hsv_convert_core.sv */
// RGB to HSV conversion core, fully pipelined, one pixel per clock.
// Depends on rgb2hsv_pkg for widths, sector codes and hue constants.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive red_in, green_in, blue_in and pulse start. A
//   transaction is taken at every rising edge with start high and busy low.
//   busy is tied low: the pipeline accepts a new pixel in every cycle.
//   Output channel: done is high for exactly one cycle with hue_out, sat_out
//   and value_out valid in that cycle. The receiver cannot stall the core,
//   so results must be captured when done is high.
//   Throughput is one transaction per cycle; the depth is set by the
//   one-bit-per-stage restoring divider used for hue (3840*|diff|/delta)
//   and, in parallel, saturation (255*delta/max).
//   Pipeline: stage A finds max, min, sector and channel difference; stage B
//   forms both numerators; DIV_N divider stages each resolve one quotient
//   bit; the output stage applies floor rounding, the sector offset and the
//   wrap of negative hue by a full turn.
//   Reset: rst clears all valid bits; payload registers are not reset, and
//   done stays low until a transaction reaches the end of the pipeline.
//   Grey pixels (max equal to min) yield hue 0 and saturation 0.
module rgb_to_hsv_convert_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0] red_in,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0] green_in,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0] blue_in,
  output logic                       done,
  output logic [rgb2hsv_pkg::HUE_W-1:0]  hue_out,
  output logic [rgb2hsv_pkg::CHAN_W-1:0] sat_out,
  output logic [rgb2hsv_pkg::CHAN_W-1:0] value_out
);
  import rgb2hsv_pkg::*;

  // Never hold off the sender.
  assign busy = 1'b0;

  // ---------------- Stage A: max, min, sector, difference ----------------
  logic              a_vld;
  side_t             a_side;
  logic [CHAN_W-1:0] a_adiff;

  side_t             a_side_next;
  logic [CHAN_W-1:0] a_adiff_next;
  logic [CHAN_W-1:0] mx, mn, dp, dn;

  always_comb begin
    mx = red_in;
    mn = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in > mx)  mx = blue_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn)  mn = blue_in;
    // Pick the sector; ties go to red, then green.
    if (red_in >= green_in && red_in >= blue_in) begin
      a_side_next.sector = SEC_RED;
      dp = green_in;
      dn = blue_in;
    end else if (green_in >= blue_in) begin
      a_side_next.sector = SEC_GREEN;
      dp = blue_in;
      dn = red_in;
    end else begin
      a_side_next.sector = SEC_BLUE;
      dp = red_in;
      dn = green_in;
    end
    a_side_next.value = mx;
    a_side_next.delta = mx - mn;
    a_side_next.neg   = (dp < dn);
    a_adiff_next      = (dp < dn) ? (dn - dp) : (dp - dn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_side  <= a_side_next;
    a_adiff <= a_adiff_next;
  end

  // ---------------- Divider pipeline (index 0 loaded by stage B) ---------
  logic                dv_vld   [0:DIV_N];
  side_t               dv_side  [0:DIV_N];
  logic [CHAN_W-1:0]   h_rem    [0:DIV_N];
  logic [HUE_QW-1:0]   h_nq     [0:DIV_N];
  logic [CHAN_W-1:0]   s_rem    [0:DIV_N];
  logic [SAT_QW-1:0]   s_nq     [0:DIV_N];

  logic [CHAN_W-1:0]   h_rem_next [0:DIV_N-1];
  logic [HUE_QW-1:0]   h_nq_next  [0:DIV_N-1];
  logic [CHAN_W-1:0]   s_rem_next [0:DIV_N-1];
  logic [SAT_QW-1:0]   s_nq_next  [0:DIV_N-1];

  logic [HUE_NUM_W-1:0] h_num;
  logic [SAT_NUM_W-1:0] s_num;

  // Stage B: numerators. Quotients fit their widths, so the top bits
  // seed the partial remainder directly.
  assign h_num = HUE_NUM_W'(HUE_UNIT * a_adiff);
  assign s_num = SAT_NUM_W'(CHAN_MAX * a_side.delta);

  // One restoring step per stage: shift in the next numerator bit, subtract
  // the divisor when it fits, shift the quotient bit into the low end.
  always_comb begin
    logic [CHAN_W:0] trial;
    logic            ge;
    for (int k = 0; k < DIV_N; k++) begin
      if (k < HUE_QW) begin
        trial = {h_rem[k], h_nq[k][HUE_QW-1]};
        ge    = (trial >= {1'b0, dv_side[k].delta});
        h_rem_next[k] = ge ? CHAN_W'(trial - {1'b0, dv_side[k].delta})
                           : trial[CHAN_W-1:0];
        h_nq_next[k]  = {h_nq[k][HUE_QW-2:0], ge};
      end else begin
        h_rem_next[k] = h_rem[k];
        h_nq_next[k]  = h_nq[k];
      end
      if (k < SAT_QW) begin
        trial = {s_rem[k], s_nq[k][SAT_QW-1]};
        ge    = (trial >= {1'b0, dv_side[k].value});
        s_rem_next[k] = ge ? CHAN_W'(trial - {1'b0, dv_side[k].value})
                           : trial[CHAN_W-1:0];
        s_nq_next[k]  = {s_nq[k][SAT_QW-2:0], ge};
      end else begin
        s_rem_next[k] = s_rem[k];
        s_nq_next[k]  = s_nq[k];
      end
    end
  end

  // Load stage B into index 0 and advance the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_N; k++) dv_vld[k] <= 1'b0;
    end else begin
      dv_vld[0] <= a_vld;
      for (int k = 1; k <= DIV_N; k++) dv_vld[k] <= dv_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    dv_side[0] <= a_side;
    h_rem[0]   <= CHAN_W'(h_num[HUE_NUM_W-1:HUE_QW]);
    h_nq[0]    <= h_num[HUE_QW-1:0];
    s_rem[0]   <= s_num[SAT_NUM_W-1:SAT_QW];
    s_nq[0]    <= s_num[SAT_QW-1:0];
    for (int k = 1; k <= DIV_N; k++) begin
      dv_side[k] <= dv_side[k-1];
      h_rem[k]   <= h_rem_next[k-1];
      h_nq[k]    <= h_nq_next[k-1];
      s_rem[k]   <= s_rem_next[k-1];
      s_nq[k]    <= s_nq_next[k-1];
    end
  end

  // ---------------- Output stage: rounding, offset, wrap -----------------
  side_t                        f_side;
  logic signed [HUE_CALC_W-1:0] f_q;
  logic signed [HUE_CALC_W-1:0] f_frac;
  logic signed [HUE_CALC_W-1:0] f_hue;
  logic [HUE_W-1:0]             hue_next;
  logic [CHAN_W-1:0]            sat_next;

  always_comb begin
    f_side = dv_side[DIV_N];
    f_q    = HUE_CALC_W'(h_nq[DIV_N]);
    // Floor of a negative fraction: negate and step down on any remainder.
    if (f_side.neg) begin
      f_frac = -(f_q + HUE_CALC_W'(h_rem[DIV_N] != '0));
    end else begin
      f_frac = f_q;
    end
    f_hue = $signed(sector_base(f_side.sector)) + f_frac;
    if (f_hue < 0) begin
      f_hue = f_hue + HUE_CALC_W'(HUE_TURN);
    end
    if (f_side.delta == '0) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      hue_next = f_hue[HUE_W-1:0];
      sat_next = s_nq[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    hue_out   <= hue_next;
    sat_out   <= sat_next;
    value_out <= f_side.value;
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for rgb_to_hsv_convert_core: drives RGB pixels with random
// gaps and checks every hue, saturation and value result against a built-in predictor.
// Depends on rgb2hsv_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import rgb2hsv_pkg::*;

  // Cycles from the accepting edge to the edge that ends the done cycle.
  localparam int PIPE_LAT   = 3 + DIV_N;
  localparam int RAND_ITEMS = 800;
  localparam int BLOCK_LEN  = 30;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] value;
  } hsv_t;

  // Scoreboard: predicts one HSV result per accepted pixel and matches the
  // results in arrival order, since the core never reorders transactions.
  class hsv_scoreboard;
    hsv_t hsv_due_q[$];
    int   accepted;
    int   checked;
    int   grey_px;
    int   wrapped_px;
    int   errors;
    int   leftover;

    function new();
      accepted   = 0;
      checked    = 0;
      grey_px    = 0;
      wrapped_px = 0;
      errors     = 0;
      leftover   = 0;
    endfunction

    // Exact integer hue: floor(unit * (offset * delta + diff) / delta).
    function hsv_t rgb_to_hsv_predict(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                      logic [CHAN_W-1:0] b);
      hsv_t    res;
      int      mx;
      int      mn;
      int      dlt;
      int      diff;
      int      offs;
      int      num;
      int      hue;
      sector_t sec;
      mx  = r;
      mn  = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dlt = mx - mn;
      res.value = CHAN_W'(mx);
      if (dlt == 0) begin
        grey_px++;
        res.hue = '0;
        res.sat = '0;
      end else begin
        res.sat = CHAN_W'((CHAN_MAX * dlt) / mx);
        // Red wins ties over green, green over blue.
        if (r == mx) sec = SEC_RED;
        else if (g == mx) sec = SEC_GREEN;
        else sec = SEC_BLUE;
        case (sec)
          SEC_RED: begin
            offs = 0;
            diff = int'(g) - int'(b);
          end
          SEC_GREEN: begin
            offs = 2;
            diff = int'(b) - int'(r);
          end
          default: begin
            offs = 4;
            diff = int'(r) - int'(g);
          end
        endcase
        num = HUE_UNIT * (offs * dlt + diff);
        hue = num / dlt;
        if ((num % dlt) != 0 && num < 0) hue = hue - 1;
        if (hue < 0) begin
          wrapped_px++;
          hue = hue + HUE_TURN;
        end
        res.hue = HUE_W'(hue);
      end
      return res;
    endfunction

    function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      accepted++;
      hsv_due_q.push_back(rgb_to_hsv_predict(r, g, b));
    endfunction

    function void check_result(hsv_t got);
      hsv_t want;
      if (hsv_due_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("[%0t] unexpected result hue=%0d sat=%0d value=%0d",
                   $time, got.hue, got.sat, got.value);
        return;
      end
      want = hsv_due_q.pop_front();
      checked++;
      if (got.hue !== want.hue || got.sat !== want.sat || got.value !== want.value) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("[%0t] mismatch on result %0d: hue %0d/%0d sat %0d/%0d value %0d/%0d (exp/act)",
                   $time, checked, want.hue, got.hue, want.sat, got.sat,
                   want.value, got.value);
      end
    endfunction

    function int pending();
      return hsv_due_q.size();
    endfunction

    // Count anything still owed as a failure.
    function void close();
      leftover = hsv_due_q.size();
      if (leftover != 0) begin
        errors += leftover;
        $display("%0d results never arrived", leftover);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic              done;
  logic [HUE_W-1:0]  hue_out;
  logic [CHAN_W-1:0] sat_out;
  logic [CHAN_W-1:0] value_out;

  hsv_scoreboard sb;

  rgb_to_hsv_convert_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .done      (done),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .value_out (value_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor: sample both channels at the rising edge, before the core's
  // registers update, so the record matches what the core actually saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_pixel(red_in, green_in, blue_in);
      if (done) sb.check_result({hue_out, sat_out, value_out});
    end
  end

  // Offer one pixel: idle at random for idle_pct percent of the cycles, then
  // hold start with the data until a rising edge sees busy low. Leave start
  // high on return so back-to-back transactions need no gap.
  task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      red_in   = CHAN_W'($urandom);
      green_in = CHAN_W'($urandom);
      blue_in  = CHAN_W'($urandom);
      @(negedge clk);
    end
    start    = 1'b1;
    red_in   = r;
    green_in = g;
    blue_in  = b;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Random pixel with a bias toward the interesting corners: grey pixels,
  // tied maxima, tiny deltas (hue division with a small divisor) and
  // saturated channels. Uniform pixels cover every bit of every channel.
  task automatic random_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
                              output logic [CHAN_W-1:0] b);
    int kind;
    int base;
    int lo;
    int pick;
    kind = $urandom_range(9);
    r = CHAN_W'($urandom);
    g = CHAN_W'($urandom);
    b = CHAN_W'($urandom);
    case (kind)
      4: begin
        g = r;
        b = r;
      end
      5: begin
        base = $urandom_range(CHAN_MAX);
        lo   = $urandom_range(base);
        pick = $urandom_range(2);
        r = CHAN_W'((pick == 2) ? lo : base);
        g = CHAN_W'((pick == 1) ? lo : base);
        b = CHAN_W'((pick == 0) ? lo : base);
      end
      6: begin
        base = $urandom_range(2, CHAN_MAX - 2);
        r = CHAN_W'(base + $urandom_range(4) - 2);
        g = CHAN_W'(base + $urandom_range(4) - 2);
        b = CHAN_W'(base + $urandom_range(4) - 2);
      end
      7: begin
        pick = $urandom_range(2);
        if (pick == 0) r = ($urandom_range(1) == 0) ? '0 : CHAN_W'(CHAN_MAX);
        if (pick != 1) g = ($urandom_range(1) == 0) ? '0 : CHAN_W'(CHAN_MAX);
        if (pick != 2) b = ($urandom_range(1) == 0) ? '0 : CHAN_W'(CHAN_MAX);
      end
      default: ;
    endcase
  endtask

  // Directed corners: black, white, grey, primaries, secondaries with tied
  // maxima, hue just below a full turn, the smallest deltas and the largest
  // negative red-sector difference.
  localparam int N_DIRECTED = 20;
  localparam logic [3*CHAN_W-1:0] DIRECTED_PX [N_DIRECTED] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000,
    24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
    24'hFF00FF, 24'hFF0001, 24'h010000, 24'h000100,
    24'h000001, 24'hFEFFFF, 24'hFFFEFE, 24'h01FF00,
    24'h7F8081, 24'hFF8040, 24'h40FF80, 24'h8040FF
  };

  initial begin : stimulus
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    int                phase_idle [3];
    int                idle_pct;
    int                sent;

    sb = new();
    phase_idle[0] = 35;
    phase_idle[1] = 73;
    phase_idle[2] = 0;

    // Hold every input at a known value through reset.
    rst      = 1'b1;
    start    = 1'b0;
    red_in   = '0;
    green_in = '0;
    blue_in  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_PX[i])
      send_pixel(DIRECTED_PX[i][23:16], DIRECTED_PX[i][15:8], DIRECTED_PX[i][7:0],
                 (i < N_DIRECTED / 2) ? 0 : 35);
    drain_results();

    // Three idling phases; inside each, some blocks run with no gaps at all.
    for (int ph = 0; ph < 3; ph++) begin
      sent = 0;
      while (sent < RAND_ITEMS / 3) begin
        idle_pct = ($urandom_range(3) == 0) ? 0 : phase_idle[ph];
        for (int k = 0; k < BLOCK_LEN && sent < RAND_ITEMS / 3; k++) begin
          random_pixel(r, g, b);
          send_pixel(r, g, b, idle_pct);
          sent++;
        end
      end
      // Stall the sender until the pipeline has fully emptied.
      drain_results();
    end

    repeat (PIPE_LAT + 4) @(posedge clk);
    sb.close();

    $display("Converted %0d pixels (%0d grey, %0d with negative hue wrapped), %0d results checked",
             sb.accepted, sb.grey_px, sb.wrapped_px, sb.checked);
    $display("Sender gaps of 35%%, 73%% and none, with full drains between phases");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard: a limit far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("Verification failed");
    $finish;
  end

endmodule
